@@ hdl/bfc_pkg.sv @@
// Shared types and constants for the box frustum culling block.
// No dependencies; imported by bfc_cell, box_frustum_cull, bfc_verdict_check and tb.
package bfc_pkg;

    localparam int PLANE_W      = 64;   // packed plane: nx, ny, nz (Q1.14), offset
    localparam int NORM_W       = 16;
    localparam int Q14_SHIFT    = 14;
    localparam int OFFSET_Q14_W = NORM_W + Q14_SHIFT;
    localparam int CFG_INDEX_W  = 3;
    localparam int AXIS_COUNT   = 3;
    localparam int CORNER_COUNT = 2 * AXIS_COUNT;  // min x,y,z then max x,y,z

    typedef enum logic [1:0] {
        VERDICT_INSIDE    = 2'd0,
        VERDICT_INTERSECT = 2'd1,
        VERDICT_OUTSIDE   = 2'd2
    } verdict_t;

    // Control travelling alongside a box through the cell chain
    typedef struct packed {
        logic valid;
        logic outside;
        logic crossed;
    } cull_flags_t;

endpackage

@@ hdl/box_frustum_cull.sv @@
// Top level of the box frustum culling block: plane registers, cell chain, output buffer.
// Depends on bfc_pkg and bfc_cell.
//
//  Channel   Ports                                   Direction  Moves
//  --------  --------------------------------------  ---------  ---------------------------
//  input     s_valid/s_ready, s_min_* / s_max_*      in         one box item per handshake
//  result    m_valid/m_ready, m_verdict              out        one verdict item per box
//  config    cfg_wr_en, cfg_index, cfg_data          in         one plane register per write
//
//  Throughput: one item per cycle while the skid register is empty; the chain has one
//  cell per plane, each a multiply stage and a sum stage, ahead of the output register.
//  Reset (aresetn low, synchronous) clears all planes to zero and empties the chain.
//  When m_ready is low the chain keeps running until the skid register fills, then the
//  whole chain holds and s_ready drops; it rises again once the skid drains.
module box_frustum_cull import bfc_pkg::*; #(
    parameter int PLANE_COUNT = 6,
    parameter int COORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // box input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_min_x,
    input  logic signed [COORD_WIDTH-1:0] s_min_y,
    input  logic signed [COORD_WIDTH-1:0] s_min_z,
    input  logic signed [COORD_WIDTH-1:0] s_max_x,
    input  logic signed [COORD_WIDTH-1:0] s_max_y,
    input  logic signed [COORD_WIDTH-1:0] s_max_z,
    // verdict output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_verdict,
    // plane register writes
    input  logic                          cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [PLANE_W-1:0]            cfg_data
);

    logic [PLANE_W-1:0]            plane_reg [PLANE_COUNT];
    logic signed [COORD_WIDTH-1:0] box_chain [PLANE_COUNT+1][CORNER_COUNT];
    cull_flags_t                   flags_chain [PLANE_COUNT+1];

    logic     en;
    logic     out_ready;
    logic     tail_valid;
    verdict_t tail_verdict;
    logic     out_valid_reg;
    verdict_t out_verdict_reg;
    logic     skid_valid_reg;
    verdict_t skid_verdict_reg;

    // Plane registers; writes to indexes past the last plane are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PLANE_COUNT; i++) begin
                plane_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            for (int i = 0; i < PLANE_COUNT; i++) begin
                if (cfg_index == CFG_INDEX_W'(i)) begin
                    plane_reg[i] <= cfg_data;
                end
            end
        end
    end

    // The whole chain advances together while the skid register is empty
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // Head of the chain: the incoming box with clean flags
    assign box_chain[0][0] = s_min_x;
    assign box_chain[0][1] = s_min_y;
    assign box_chain[0][2] = s_min_z;
    assign box_chain[0][3] = s_max_x;
    assign box_chain[0][4] = s_max_y;
    assign box_chain[0][5] = s_max_z;
    assign flags_chain[0]  = '{valid: s_valid, outside: 1'b0, crossed: 1'b0};

    // One cell per plane, tested in register order
    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_cell
        bfc_cell #(
            .COORD_WIDTH(COORD_WIDTH)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .plane_i (plane_reg[p]),
            .box_i   (box_chain[p]),
            .flags_i (flags_chain[p]),
            .box_o   (box_chain[p+1]),
            .flags_o (flags_chain[p+1])
        );
    end

    // Tail: fold the flags into a verdict. The box corners are not needed past here.
    assign tail_valid   = flags_chain[PLANE_COUNT].valid;
    assign tail_verdict = flags_chain[PLANE_COUNT].outside ? VERDICT_OUTSIDE   :
                          flags_chain[PLANE_COUNT].crossed ? VERDICT_INTERSECT :
                                                             VERDICT_INSIDE;

    // Output register with a one-item skid behind it
    assign out_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= tail_valid;
            end
        end else if (en && tail_valid) begin
            // output stalled: park the item leaving the chain
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            out_verdict_reg <= skid_valid_reg ? skid_verdict_reg : tail_verdict;
        end
        if (!out_ready && en && tail_valid) begin
            skid_verdict_reg <= tail_verdict;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_verdict = out_verdict_reg;

    // The skid only fills behind a held output item
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // An item leaving the chain into a stalled output must be parked
    a_park_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && tail_valid && !out_ready) |=> skid_valid_reg)
        else $error("item lost at stalled output");

    // An item leaving the chain into a free output appears on m_valid
    a_pass_on_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && tail_valid && out_ready) |=> out_valid_reg && !skid_valid_reg)
        else $error("item lost at free output");

endmodule

@@ hdl/bfc_cell.sv @@
// One plane-test cell of the culling chain: multiply stage, then sum-and-sign stage.
// Depends on bfc_pkg.
module bfc_cell import bfc_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic [PLANE_W-1:0]            plane_i,
    input  logic signed [COORD_WIDTH-1:0] box_i [CORNER_COUNT],
    input  cull_flags_t                   flags_i,
    output logic signed [COORD_WIDTH-1:0] box_o [CORNER_COUNT],
    output cull_flags_t                   flags_o
);

    localparam int PROD_W = NORM_W + COORD_WIDTH;
    localparam int SUM_W  = ((PROD_W > OFFSET_Q14_W) ? PROD_W : OFFSET_Q14_W) + 2;

    logic signed [PROD_W-1:0]      prod_far_reg  [AXIS_COUNT];
    logic signed [PROD_W-1:0]      prod_near_reg [AXIS_COUNT];
    logic signed [PROD_W-1:0]      prod_far_next [AXIS_COUNT];
    logic signed [PROD_W-1:0]      prod_near_next[AXIS_COUNT];
    logic signed [COORD_WIDTH-1:0] box_a_reg     [CORNER_COUNT];
    logic signed [COORD_WIDTH-1:0] box_b_reg     [CORNER_COUNT];
    cull_flags_t                   flags_a_reg;
    cull_flags_t                   flags_b_reg;
    cull_flags_t                   flags_b_next;
    logic signed [OFFSET_Q14_W-1:0] offset_q14;
    logic signed [SUM_W-1:0]       dist_far;
    logic signed [SUM_W-1:0]       dist_near;

    // Stage A: pick far and near corner per axis by the sign of the normal component, and multiply
    always_comb begin
        logic signed [NORM_W-1:0]      n;
        logic signed [COORD_WIDTH-1:0] far_c;
        logic signed [COORD_WIDTH-1:0] near_c;
        for (int a = 0; a < AXIS_COUNT; a++) begin
            n      = plane_i[NORM_W*a +: NORM_W];
            far_c  = n[NORM_W-1] ? box_i[a] : box_i[a+AXIS_COUNT];
            near_c = n[NORM_W-1] ? box_i[a+AXIS_COUNT] : box_i[a];
            prod_far_next[a]  = PROD_W'(n) * PROD_W'(far_c);
            prod_near_next[a] = PROD_W'(n) * PROD_W'(near_c);
        end
    end

    // Stage B: signed distances; only the sign matters
    assign offset_q14 = {plane_i[NORM_W*AXIS_COUNT +: NORM_W], {Q14_SHIFT{1'b0}}};

    always_comb begin
        dist_far  = SUM_W'(prod_far_reg[0]) + SUM_W'(prod_far_reg[1])
                  + SUM_W'(prod_far_reg[2]) + SUM_W'(offset_q14);
        dist_near = SUM_W'(prod_near_reg[0]) + SUM_W'(prod_near_reg[1])
                  + SUM_W'(prod_near_reg[2]) + SUM_W'(offset_q14);
        flags_b_next = flags_a_reg;
        // an earlier plane already rejected the box: pass it through untouched
        if (!flags_a_reg.outside) begin
            flags_b_next.outside = dist_far[SUM_W-1];
            flags_b_next.crossed = flags_a_reg.crossed | dist_near[SUM_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_a_reg <= '0;
            flags_b_reg <= '0;
        end else if (en) begin
            flags_a_reg <= flags_i;
            flags_b_reg <= flags_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_far_reg  <= prod_far_next;
            prod_near_reg <= prod_near_next;
            box_a_reg     <= box_i;
            box_b_reg     <= box_a_reg;
        end
    end

    assign box_o   = box_b_reg;
    assign flags_o = flags_b_reg;

endmodule

@@ tb/sv/bfc_verdict_check.sv @@
`timescale 1ns / 100ps
// Verdict checker for box_frustum_cull: mirrors the plane registers, predicts each verdict.
// Depends on bfc_pkg; instantiated beside the block by tb.
module bfc_verdict_check import bfc_pkg::*; #(
    parameter int PLANE_COUNT = 6,
    parameter int COORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_min_x,
    input  logic signed [COORD_WIDTH-1:0] s_min_y,
    input  logic signed [COORD_WIDTH-1:0] s_min_z,
    input  logic signed [COORD_WIDTH-1:0] s_max_x,
    input  logic signed [COORD_WIDTH-1:0] s_max_y,
    input  logic signed [COORD_WIDTH-1:0] s_max_z,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [1:0]                    m_verdict,
    input  logic                          cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [PLANE_W-1:0]            cfg_data,
    output int                            fail_count,
    output int                            pending
);

    localparam int     PLANE_REGS = 6;
    localparam longint Q14_ONE    = longint'(1) << Q14_SHIFT;

    logic [PLANE_W-1:0] plane_q [PLANE_REGS];
    verdict_t           verdict_q [$];

    // Test planes in order; the far corner behind any plane ends the search.
    function automatic verdict_t classify_box(input longint lo [AXIS_COUNT],
                                              input longint hi [AXIS_COUNT]);
        longint nrm;
        longint offset;
        longint d_far;
        longint d_near;
        logic   crossed;
        crossed = 1'b0;
        for (int p = 0; p < PLANE_COUNT && p < PLANE_REGS; p++) begin
            offset = longint'($signed(plane_q[p][PLANE_W-1 -: NORM_W]));
            d_far  = offset * Q14_ONE;
            d_near = d_far;
            for (int a = 0; a < AXIS_COUNT; a++) begin
                nrm = longint'($signed(plane_q[p][a*NORM_W +: NORM_W]));
                if (nrm >= 0) begin
                    d_far  += nrm * hi[a];
                    d_near += nrm * lo[a];
                end else begin
                    d_far  += nrm * lo[a];
                    d_near += nrm * hi[a];
                end
            end
            if (d_far < 0)
                return VERDICT_OUTSIDE;
            if (d_near < 0)
                crossed = 1'b1;
        end
        return crossed ? VERDICT_INTERSECT : VERDICT_INSIDE;
    endfunction

    // both counts are two-state and start at zero
    always @(posedge aclk) begin : watch
        longint   lo [AXIS_COUNT];
        longint   hi [AXIS_COUNT];
        verdict_t want;
        if (!aresetn) begin
            foreach (plane_q[i])
                plane_q[i] = '0;
            verdict_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: verdict %0d with none pending", $realtime, m_verdict);
                    fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (m_verdict !== 2'(want)) begin
                        if (fail_count < 10)
                            $display("%0t: verdict mismatch, expected %0d, got %0d",
                                     $realtime, want, m_verdict);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                lo[0] = s_min_x;
                lo[1] = s_min_y;
                lo[2] = s_min_z;
                hi[0] = s_max_x;
                hi[1] = s_max_y;
                hi[2] = s_max_z;
                verdict_q.push_back(classify_box(lo, hi));
            end
            // indices past the last plane are dropped
            if (cfg_wr_en && cfg_index < PLANE_REGS)
                plane_q[cfg_index] = cfg_data;
        end
        pending = verdict_q.size();
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Top of the box_frustum_cull testbench: clock, reset, box and plane stimulus, verdict.
// Depends on bfc_pkg, box_frustum_cull and bfc_verdict_check.
module tb;
    import bfc_pkg::*;

    localparam int PLANE_COUNT = 6;
    localparam int COORD_WIDTH = 16;
    localparam int PLANE_REGS  = 6;
    localparam int LATENCY     = 2 * PLANE_COUNT;
    localparam int PHASE_ITEMS = 64;
    localparam int RAND_PHASES = 7;

    // plane register indices; the last two address nothing
    localparam logic [CFG_INDEX_W-1:0] REG_NEAR    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FAR     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TOP     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LEFT    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

    typedef logic [PLANE_W-1:0] plane_set_t [PLANE_REGS];

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [COORD_WIDTH-1:0] s_min_x;
    logic signed [COORD_WIDTH-1:0] s_min_y;
    logic signed [COORD_WIDTH-1:0] s_min_z;
    logic signed [COORD_WIDTH-1:0] s_max_x;
    logic signed [COORD_WIDTH-1:0] s_max_y;
    logic signed [COORD_WIDTH-1:0] s_max_z;
    logic                          m_valid;
    logic                          m_ready;
    logic [1:0]                    m_verdict;
    logic                          cfg_wr_en;
    logic [CFG_INDEX_W-1:0]        cfg_index;
    logic [PLANE_W-1:0]            cfg_data;

    int fail_count;
    int pending;
    int boxes_sent;
    int tx_idle_pct;
    int rx_idle_pct;

    box_frustum_cull #(
        .PLANE_COUNT (PLANE_COUNT),
        .COORD_WIDTH (COORD_WIDTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_min_x   (s_min_x),
        .s_min_y   (s_min_y),
        .s_min_z   (s_min_z),
        .s_max_x   (s_max_x),
        .s_max_y   (s_max_y),
        .s_max_z   (s_max_z),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_verdict (m_verdict),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bfc_verdict_check #(
        .PLANE_COUNT (PLANE_COUNT),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_verdict_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_min_x    (s_min_x),
        .s_min_y    (s_min_y),
        .s_min_z    (s_min_z),
        .s_max_x    (s_max_x),
        .s_max_y    (s_max_y),
        .s_max_z    (s_max_z),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_verdict  (m_verdict),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Stall the result side at random; the rate follows the idling regime of the moment.
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= rx_idle_pct);
    end

    // Hard stop: far beyond the slowest correct run.
    initial begin
        #1000000;
        $display("tb NOT OK");
        $finish;
    end

    // One plane facing inwards along one axis, offset by half, with a random tilt on the
    // other two axes and a random shortening of the main component.
    function automatic logic [PLANE_W-1:0] tilted_plane(input int axis, input int sgn,
                                                         input int half, input int tilt);
        int n [AXIS_COUNT];
        for (int a = 0; a < AXIS_COUNT; a++)
            n[a] = int'($urandom_range(0, 2 * tilt)) - tilt;
        n[axis] = sgn * (16384 - int'($urandom_range(0, tilt)));
        return {NORM_W'(half), NORM_W'(n[2]), NORM_W'(n[1]), NORM_W'(n[0])};
    endfunction

    // Six planes bounding a roughly cubic region of the given half size around the origin.
    function automatic plane_set_t cube_planes(input int half, input int tilt);
        plane_set_t pl;
        pl[REG_NEAR]   = tilted_plane(2,  1, half, tilt);
        pl[REG_FAR]    = tilted_plane(2, -1, half, tilt);
        pl[REG_TOP]    = tilted_plane(1, -1, half, tilt);
        pl[REG_BOTTOM] = tilted_plane(1,  1, half, tilt);
        pl[REG_LEFT]   = tilted_plane(0,  1, half, tilt);
        pl[REG_RIGHT]  = tilted_plane(0, -1, half, tilt);
        return pl;
    endfunction

    // Hold the write for one cycle; the caller drops the enable after its last write.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [PLANE_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
    endtask

    // Drop valid and wait until every verdict has come back: the chain is then empty.
    task automatic drain_boxes();
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
    endtask

    task automatic load_planes(input plane_set_t pl);
        drain_boxes();
        write_reg(REG_NEAR,   pl[REG_NEAR]);
        write_reg(REG_FAR,    pl[REG_FAR]);
        write_reg(REG_TOP,    pl[REG_TOP]);
        write_reg(REG_BOTTOM, pl[REG_BOTTOM]);
        write_reg(REG_LEFT,   pl[REG_LEFT]);
        write_reg(REG_RIGHT,  pl[REG_RIGHT]);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one box and hold it until taken. Called and returns at a falling edge; valid
    // is left high so that a back-to-back item needs no second assignment in one step.
    task automatic send_box(input int lx, input int ly, input int lz,
                            input int hx, input int hy, input int hz);
        if (boxes_sent < 160) begin
            tx_idle_pct = 23;
            rx_idle_pct = 80;
        end else if (boxes_sent < 320) begin
            tx_idle_pct = 80;
            rx_idle_pct = 23;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_min_x <= COORD_WIDTH'(lx);
        s_min_y <= COORD_WIDTH'(ly);
        s_min_z <= COORD_WIDTH'(lz);
        s_max_x <= COORD_WIDTH'(hx);
        s_max_y <= COORD_WIDTH'(hy);
        s_max_z <= COORD_WIDTH'(hz);
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        boxes_sent++;
        @(negedge aclk);
    endtask

    // Mostly boxes scattered around and across the region; one in four is raw noise,
    // which also gives min above max and the full range of every bit.
    task automatic send_random_box(input int half);
        int lo [AXIS_COUNT];
        int hi [AXIS_COUNT];
        int mid;
        int ext;
        if ($urandom_range(3) == 0) begin
            for (int a = 0; a < AXIS_COUNT; a++) begin
                lo[a] = $urandom;
                hi[a] = $urandom;
            end
        end else begin
            for (int a = 0; a < AXIS_COUNT; a++) begin
                mid = int'($urandom_range(0, 3 * half)) - 3 * half / 2;
                ext = ($urandom_range(7) == 0) ? int'($urandom_range(0, 2 * half))
                                               : int'($urandom_range(0, half / 2));
                lo[a] = mid - ext;
                hi[a] = mid + ext;
                if (lo[a] < -32768)
                    lo[a] = -32768;
                if (hi[a] > 32767)
                    hi[a] = 32767;
            end
        end
        send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endtask

    initial begin
        plane_set_t pl;
        int         half;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_min_x     = '0;
        s_min_y     = '0;
        s_min_z     = '0;
        s_max_x     = '0;
        s_max_y     = '0;
        s_max_z     = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        boxes_sent  = 0;
        tx_idle_pct = 23;
        rx_idle_pct = 80;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Planes straight out of reset: every distance is zero, so everything is inside,
        // whatever the corners, even with min above max.
        send_box(-32768, -32768, -32768, 32767, 32767, 32767);
        send_box(0, 0, 0, 0, 0, 0);
        send_box(100, -5, 32767, -100, -32768, 5);

        // Axis-aligned cube of half size 1000: two normal components of every plane are
        // zero, which must pick the max corner as the far one.
        pl = cube_planes(1000, 0);
        load_planes(pl);
        send_box(-10, -10, -10, 10, 10, 10);
        send_box(-2000, -10, -10, 0, 10, 10);
        send_box(2000, -10, -10, 3000, 10, 10);
        // touching the boundary gives distance zero, which is not behind
        send_box(1000, 1000, 1000, 1000, 1000, 1000);
        send_box(1001, 0, 0, 1001, 0, 0);
        send_box(0, -1001, 0, 0, -1000, 0);
        // min above max: corners taken as given, no swap
        send_box(500, -500, 0, -500, 500, 0);
        send_box(-32768, -32768, -32768, 32767, 32767, 32767);
        send_box(-32768, -32768, -32768, -32768, -32768, -32768);
        send_box(32767, 32767, 32767, 32767, 32767, 32767);

        // Writes past the last plane must leave the cube alone.
        drain_boxes();
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, '1);
        cfg_wr_en <= 1'b0;
        send_box(-10, -10, -10, 10, 10, 10);

        // Extreme register contents: most negative, most positive, all ones.
        pl = '{default: 64'h8000_8000_8000_8000};
        load_planes(pl);
        send_box(-32768, -32768, -32768, 32767, 32767, 32767);
        send_box(-32768, -32768, -32768, -32768, -32768, -32768);
        pl = '{default: 64'h7fff_7fff_7fff_7fff};
        load_planes(pl);
        send_box(-32768, -32768, -32768, 32767, 32767, 32767);
        send_box(32767, 32767, 32767, 32767, 32767, 32767);
        pl = '{default: '1};
        load_planes(pl);
        send_box(-32768, -32768, -32768, 32767, 32767, 32767);
        send_box(0, 0, 0, 0, 0, 0);

        // Random part: rotate through tilted cubes, raw register noise, and tilted cubes
        // with some planes cleared to zero.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            half = $urandom_range(300, 20000);
            case (ph % 3)
                0: begin
                    pl = cube_planes(half, $urandom_range(0, 3000));
                end
                1: begin
                    for (int i = 0; i < PLANE_REGS; i++)
                        pl[i] = {$urandom, $urandom};
                end
                default: begin
                    pl = cube_planes(half, $urandom_range(0, 3000));
                    for (int i = 0; i < PLANE_REGS; i++)
                        if ($urandom_range(2) == 0)
                            pl[i] = '0;
                end
            endcase
            load_planes(pl);
            repeat (PHASE_ITEMS)
                send_random_box(half);
        end

        // Wait for the last verdicts, then a little longer to catch strays.
        drain_boxes();
        repeat (LATENCY + 4) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

@@ box_frustum_cull.f @@
hdl/bfc_pkg.sv
hdl/bfc_cell.sv
hdl/box_frustum_cull.sv
tb/sv/bfc_verdict_check.sv
tb/sv/tb.sv
